// ===== sv/q4bd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4bd_pkg
// Types, constants and helper functions of the Q4_0 x Q8_0 block dot unit.
// ----------------------------------------------------------------------------
package q4bd_pkg;

    localparam int BLOCK_LEN = 32;
    localparam int LANES     = 8;
    localparam int PASSES    = BLOCK_LEN / LANES;
    localparam int PASS_W    = $clog2(PASSES);

    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam logic [4:0]  NIBBLE_BIAS = 5'd8;
    localparam logic [31:0] FP32_QNAN   = 32'h7FC0_0000;
    localparam logic [7:0]  FP32_EXP_MAX = 8'hFF;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DOT  = 6'b000010,
        S_FE   = 6'b000100,
        S_NM   = 6'b001000,
        S_RD   = 6'b010000,
        S_END  = 6'b100000
    } t_state;

    // operations issued to the shared float unit, in issue order
    typedef enum logic [1:0] {
        OP_SCALE = 2'd0,
        OP_I2F   = 2'd1,
        OP_PROD  = 2'd2,
        OP_ACC   = 2'd3
    } t_op;

    // exact fp16 to fp32 bit conversion
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  msb;
        logic [9:0]  nman;
        logic [7:0]  e;
        logic [31:0] res;
        ex   = h[14:10];
        man  = h[9:0];
        msb  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                msb = 4'(i);
            end
        end
        nman = man << (4'd10 - msb);
        e    = 8'd103 + {4'd0, msb};
        if (ex == 5'h1F) begin
            res = {h[15], FP32_EXP_MAX, man, 13'd0};
        end else if (ex == 5'd0) begin
            if (man == 10'd0) begin
                res = {h[15], 31'd0};
            end else begin
                res = {h[15], e, nman, 13'd0};
            end
        end else begin
            res = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return res;
    endfunction

    // leading zero count of a 48-bit word
    function automatic logic [5:0] lzc48(input logic [47:0] m);
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) begin
                lz = 6'(47 - i);
            end
        end
        return lz;
    endfunction

endpackage
`default_nettype wire

// ===== sv/q4bd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4bd channel interfaces
// Valid/ready channels for weight/activation blocks and finished row sums.
// ----------------------------------------------------------------------------
interface q4bd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] weight_bytes_low;
    logic [63:0] weight_bytes_high;
    logic [15:0] weight_scale;
    logic [63:0] acts_0;
    logic [63:0] acts_1;
    logic [63:0] acts_2;
    logic [63:0] acts_3;
    logic [31:0] act_scale;
    logic        last_block;

    modport source(
        output valid, weight_bytes_low, weight_bytes_high, weight_scale,
               acts_0, acts_1, acts_2, acts_3, act_scale, last_block,
        input  ready
    );
    modport sink(
        input  valid, weight_bytes_low, weight_bytes_high, weight_scale,
               acts_0, acts_1, acts_2, acts_3, act_scale, last_block,
        output ready
    );
endinterface

interface q4bd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_sum;

    modport source(output valid, row_sum, input ready);
    modport sink(input valid, row_sum, output ready);
endinterface
`default_nettype wire

// ===== sv/q4_block_dot_accumulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q4_block_dot_accumulator_unit
// Q4_0 weight block times Q8_0 activation block, accumulated into fp32.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one 32-element block per word: 16 weight bytes, the fp16
//   weight scale, 32 int8 activations and the fp32 activation scale.
//   last_block marks the final block of a row. o_out carries one fp32 row
//   sum per row, given after the last block; NaN sums come out as 7FC00000.
// Sequence:
//   A block is accepted only when the sequencer is idle, after the last one
//   has run 4 passes of an 8-lane integer multiply-add, four operations on
//   one shared float unit (scale multiply, int to float, product,
//   accumulate), each through operand/multiply, normalize and round, and
//   the end state that finishes the block. The row sum is loaded into the
//   output register in the end state, after the accumulator takes the final sum.
// Reset:
//   Clears the accumulator to +0.0, the output valid flag and the sequencer.
// Backpressure:
//   The row sum sits in an output register; the next block is accepted
//   while it waits. A further row end holds the sequencer until the waiting
//   sum is taken.
// ----------------------------------------------------------------------------
module q4_block_dot_accumulator_unit
    import q4bd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    q4bd_in_if.sink      i_in,
    q4bd_out_if.source   o_out
);

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [PASS_W-1:0]     r_pass, n_pass;
    logic [127:0]          r_w, n_w;
    logic [255:0]          r_acts, n_acts;
    logic [31:0]           r_ws, n_ws;
    logic [31:0]           r_as, n_as;
    logic                  r_last, n_last;
    logic signed [16:0]    r_isum, n_isum;
    logic [31:0]           r_scale, n_scale;
    logic [31:0]           r_fsum, n_fsum;
    logic [31:0]           r_prod, n_prod;
    logic [31:0]           r_acc, n_acc;
    logic                  r_out_valid, n_out_valid;
    logic [31:0]           r_out_data, n_out_data;

    // shared float unit pipeline registers
    logic                  r_fe_sign, n_fe_sign;
    logic [47:0]           r_fe_m, n_fe_m;
    logic signed [10:0]    r_fe_x, n_fe_x;
    logic                  r_fe_spec, n_fe_spec;
    logic [31:0]           r_fe_sval, n_fe_sval;
    logic                  r_nm_sign, n_nm_sign;
    logic [47:0]           r_nm_m, n_nm_m;
    logic signed [10:0]    r_nm_be, n_nm_be;
    logic                  r_nm_zero, n_nm_zero;
    logic                  r_nm_spec, n_nm_spec;
    logic [31:0]           r_nm_sval, n_nm_sval;

    logic                  w_accept;
    logic signed [16:0]    w_dot;
    logic [31:0]           w_rnd;

    assign i_in.ready    = (r_state == S_IDLE);
    assign w_accept      = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.row_sum = r_out_data;

    // 8-lane integer multiply-add, one pass per cycle
    always_comb begin : dot_lanes
        logic [63:0]        w_half;
        logic [3:0]         nib;
        logic signed [4:0]  wv;
        logic signed [7:0]  av;
        logic signed [12:0] p;
        w_half = r_pass[0] ? r_w[127:64] : r_w[63:0];
        w_dot  = r_isum;
        for (int l = 0; l < LANES; l++) begin
            nib   = r_pass[PASS_W-1] ? w_half[8*l+4 +: 4] : w_half[8*l +: 4];
            nib   = nib & NIBBLE_MASK;
            wv    = $signed({1'b0, nib}) - $signed(NIBBLE_BIAS);
            av    = $signed(r_acts[8*l +: 8]);
            p     = wv * av;
            w_dot = w_dot + 17'(p);
        end
    end

    // float unit front end: operand unpack, multiply, align-add or int to float
    always_comb begin : fpu_front
        logic [31:0]        a, b, big, sml;
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]         ea, eb, eg, es;
        logic [23:0]        ma, mb, mg, ms;
        logic [7:0]         d;
        logic [47:0]        bs, bsh;
        logic               lost;
        logic [47:0]        abig;
        logic [47:0]        sum;
        logic [16:0]        mag;
        a = r_ws;
        b = r_as;
        case (r_op)
            OP_SCALE: begin a = r_ws;    b = r_as;   end
            OP_PROD:  begin a = r_scale; b = r_fsum; end
            OP_ACC:   begin a = r_acc;   b = r_prod; end
            default:  begin a = r_ws;    b = r_as;   end
        endcase
        a_nan  = (a[30:23] == FP32_EXP_MAX) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == FP32_EXP_MAX) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == FP32_EXP_MAX) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == FP32_EXP_MAX) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};

        // order by magnitude for the adder
        if (b[30:0] > a[30:0]) begin
            big = b; sml = a; eg = eb; es = ea; mg = mb; ms = ma;
        end else begin
            big = a; sml = b; eg = ea; es = eb; mg = ma; ms = mb;
        end
        d    = eg - es;
        abig = {1'b0, mg, 23'd0};
        bs   = {1'b0, ms, 23'd0};
        bsh  = bs >> d;
        lost = |(bs & ~({48{1'b1}} << d));
        bsh  = bsh | {47'd0, lost};
        sum  = (big[31] ^ sml[31]) ? (abig - bsh) : (abig + bsh);
        mag  = r_isum[16] ? 17'(-r_isum) : 17'(r_isum);

        n_fe_sign = a[31] ^ b[31];
        n_fe_m    = ma * mb;
        n_fe_x    = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd300;
        n_fe_spec = 1'b0;
        n_fe_sval = FP32_QNAN;
        case (r_op)
            OP_I2F: begin
                n_fe_sign = r_isum[16];
                n_fe_m    = {31'd0, mag};
                n_fe_x    = 11'sd0;
            end
            OP_ACC: begin
                n_fe_m    = sum;
                n_fe_x    = $signed({3'd0, eg}) - 11'sd173;
                n_fe_sign = (sum == 48'd0) ? (a[31] & b[31]) : big[31];
                if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
                    n_fe_spec = 1'b1;
                end else if (a_inf) begin
                    n_fe_spec = 1'b1;
                    n_fe_sval = a;
                end else if (b_inf) begin
                    n_fe_spec = 1'b1;
                    n_fe_sval = b;
                end
            end
            default: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                    n_fe_spec = 1'b1;
                end else if (a_inf || b_inf) begin
                    n_fe_spec = 1'b1;
                    n_fe_sval = {a[31] ^ b[31], FP32_EXP_MAX, 23'd0};
                end
            end
        endcase
    end

    // normalize stage
    always_comb begin : fpu_norm
        logic [5:0] lz;
        lz        = lzc48(r_fe_m);
        n_nm_m    = r_fe_m << lz;
        n_nm_be   = r_fe_x - $signed({5'd0, lz}) + 11'sd174;
        n_nm_zero = (r_fe_m == 48'd0);
        n_nm_sign = r_fe_sign;
        n_nm_spec = r_fe_spec;
        n_nm_sval = r_fe_sval;
    end

    // denormalize, round to nearest even, pack
    always_comb begin : fpu_round
        logic [5:0]  sh;
        logic [47:0] t;
        logic        lost, g, st, inc;
        logic [7:0]  field;
        logic [22:0] man;
        logic [30:0] mag;
        if (r_nm_be < -11'sd62) begin
            sh = 6'd63;
        end else if (r_nm_be < 11'sd1) begin
            sh = 6'(11'sd1 - r_nm_be);
        end else begin
            sh = 6'd0;
        end
        t     = r_nm_m >> sh;
        lost  = |(r_nm_m & ~({48{1'b1}} << sh));
        field = (r_nm_be < 11'sd1) ? 8'd0 : r_nm_be[7:0];
        man   = t[46:24];
        g     = t[23];
        st    = (|t[22:0]) | lost;
        inc   = g & (st | man[0]);
        mag   = {field, man} + {30'd0, inc};
        if (r_nm_spec) begin
            w_rnd = r_nm_sval;
        end else if (r_nm_zero) begin
            w_rnd = {r_nm_sign, 31'd0};
        end else if (r_nm_be >= 11'sd255) begin
            w_rnd = {r_nm_sign, FP32_EXP_MAX, 23'd0};
        end else begin
            w_rnd = {r_nm_sign, mag};
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pass      = r_pass;
        n_w         = r_w;
        n_acts      = r_acts;
        n_ws        = r_ws;
        n_as        = r_as;
        n_last      = r_last;
        n_isum      = r_isum;
        n_scale     = r_scale;
        n_fsum      = r_fsum;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // drop the word once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_w    = {i_in.weight_bytes_high, i_in.weight_bytes_low};
                    n_acts = {i_in.acts_3, i_in.acts_2, i_in.acts_1, i_in.acts_0};
                    n_ws   = half_to_single(i_in.weight_scale);
                    n_as   = i_in.act_scale;
                    n_last = i_in.last_block;
                    n_isum = '0;
                    n_pass = '0;
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                n_isum = w_dot;
                n_acts = r_acts >> (8 * LANES);
                n_pass = r_pass + 1'b1;
                if (r_pass == PASS_W'(PASSES - 1)) begin
                    n_op    = OP_SCALE;
                    n_state = S_FE;
                end
            end
            S_FE: n_state = S_NM;
            S_NM: n_state = S_RD;
            S_RD: begin
                n_state = S_FE;
                case (r_op)
                    OP_SCALE: begin n_scale = w_rnd; n_op = OP_I2F;  end
                    OP_I2F:   begin n_fsum  = w_rnd; n_op = OP_PROD; end
                    OP_PROD:  begin n_prod  = w_rnd; n_op = OP_ACC;  end
                    default:  begin n_acc   = w_rnd; n_state = S_END; end
                endcase
            end
            S_END: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    if ((r_acc[30:23] == FP32_EXP_MAX) && (r_acc[22:0] != 23'd0)) begin
                        n_out_data = FP32_QNAN;
                    end else begin
                        n_out_data = r_acc;
                    end
                    n_acc   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SCALE;
            r_pass      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_pass      <= n_pass;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w        <= n_w;
        r_acts     <= n_acts;
        r_ws       <= n_ws;
        r_as       <= n_as;
        r_last     <= n_last;
        r_isum     <= n_isum;
        r_scale    <= n_scale;
        r_fsum     <= n_fsum;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
        r_fe_sign  <= n_fe_sign;
        r_fe_m     <= n_fe_m;
        r_fe_x     <= n_fe_x;
        r_fe_spec  <= n_fe_spec;
        r_fe_sval  <= n_fe_sval;
        r_nm_sign  <= n_nm_sign;
        r_nm_m     <= n_nm_m;
        r_nm_be    <= n_nm_be;
        r_nm_zero  <= n_nm_zero;
        r_nm_spec  <= n_nm_spec;
        r_nm_sval  <= n_nm_sval;
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DOT) && (r_pass == '0))
        else $error("accepted word did not start the dot passes");

    a_dot_to_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOT) && (r_pass == PASS_W'(PASSES - 1))
        |=> (r_state == S_FE) && (r_op == OP_SCALE))
        else $error("dot passes did not hand over to the scale multiply");

    a_acc_then_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) && (r_op == OP_ACC) |=> (r_state == S_END))
        else $error("accumulate did not finish the block");

    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END) && r_last && (!r_out_valid || o_out.ready)
        |=> (r_acc == 32'd0) && r_out_valid)
        else $error("row end did not emit and clear the accumulator");

    a_nan_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_data[30:23] == FP32_EXP_MAX) && (r_out_data[22:0] != 23'd0)
        |-> (r_out_data == FP32_QNAN))
        else $error("row sum NaN is not canonical");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Q4_0 weight blocks with int8 activations into the block dot unit
// and checks every row sum against a bit-exact fp32 model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import q4bd_pkg::*;

    localparam int IDLE_PCT   = 13;
    localparam int WATCHDOG   = 4000;
    localparam int HOLD_LONG  = 300;
    localparam logic [31:0] F_QNAN = 32'h7FC0_0000;

    typedef struct {
        logic [63:0] wlo;
        logic [63:0] whi;
        logic [15:0] wscale;
        logic [63:0] acts [4];
        logic [31:0] ascale;
        logic        last;
    } t_block;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    q4bd_in_if  in_ch();
    q4bd_out_if out_ch();

    q4_block_dot_accumulator_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    logic [31:0] row_acc = 32'h0;
    logic [31:0] row_sums_due [$];
    int          errors = 0;
    bit          quiet = 1'b0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_cycles = 0;
    int          stall_count = 0;

    // ---------------- fp32 arithmetic, round to nearest even ----------------

    function automatic logic [31:0] fp_round(input logic s, input logic [319:0] m,
                                             input int e);
        int          p;
        int          shift;
        int          lsbexp;
        int          expfield;
        logic [319:0] q;
        logic [319:0] rem;
        logic [319:0] half;
        if (m == '0) return {s, 31'd0};
        p = 0;
        for (int i = 0; i < 320; i++) if (m[i]) p = i;
        shift = p - 23;
        if (p + e < -126) shift = -149 - e;
        if (shift <= 0) begin
            q = m << (-shift);
        end else begin
            q    = m >> shift;
            rem  = m & ((320'd1 << shift) - 320'd1);
            half = 320'd1 << (shift - 1);
            if (rem > half || (rem == half && q[0])) q = q + 320'd1;
        end
        lsbexp = e + shift;
        if (q[24]) begin
            q = q >> 1;
            lsbexp++;
        end
        if (!q[23]) return {s, 8'd0, q[22:0]};
        expfield = lsbexp + 150;
        if (expfield >= 255) return {s, 8'hFF, 23'd0};
        return {s, 8'(expfield), q[22:0]};
    endfunction

    function automatic void fp_split(input logic [31:0] f, output logic [319:0] m,
                                     output int e);
        if (f[30:23] == 8'd0) begin
            m = 320'(f[22:0]);
            e = -149;
        end else begin
            m = 320'({1'b1, f[22:0]});
            e = int'(f[30:23]) - 150;
        end
    endfunction

    function automatic bit is_nan(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function automatic bit is_inf(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] == 0;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic [319:0] ma, mb;
        int           ea, eb;
        logic         s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return F_QNAN;
        if (is_inf(a) || is_inf(b)) begin
            if (a[30:0] == 0 || b[30:0] == 0) return F_QNAN;
            return {s, 8'hFF, 23'd0};
        end
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        return fp_round(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [319:0] ma, mb;
        int           ea, eb, emin;
        if (is_nan(a) || is_nan(b)) return F_QNAN;
        if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : F_QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        fp_split(a, ma, ea);
        fp_split(b, mb, eb);
        emin = (ea < eb) ? ea : eb;
        ma = ma << (ea - emin);
        mb = mb << (eb - emin);
        if (a[31] == b[31]) return fp_round(a[31], ma + mb, emin);
        if (ma == mb) return 32'h0;
        if (ma > mb) return fp_round(a[31], ma - mb, emin);
        return fp_round(b[31], mb - ma, emin);
    endfunction

    function automatic logic [31:0] half_to_fp32(input logic [15:0] h);
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
        if (h[14:10] == 5'd0) return fp_round(h[15], 320'(h[9:0]), -24);
        return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    endfunction

    function automatic int block_dot(input t_block b);
        int          sum;
        logic [7:0]  wb;
        int          k;
        sum = 0;
        for (int j = 0; j < 16; j++) begin
            wb = (j < 8) ? b.wlo[8*j +: 8] : b.whi[8*(j-8) +: 8];
            k  = j + 16;
            sum += (int'(wb[3:0]) - 8) * int'($signed(b.acts[j >> 3][8*(j & 7) +: 8]));
            sum += (int'(wb[7:4]) - 8) * int'($signed(b.acts[k >> 3][8*(k & 7) +: 8]));
        end
        return sum;
    endfunction

    // fold one accepted block into the row sum, queue the sum at row end
    task automatic accumulate_block(input t_block b);
        int          isum;
        logic [31:0] scale, fsum;
        isum  = block_dot(b);
        scale = fp_mul(half_to_fp32(b.wscale), b.ascale);
        fsum  = fp_round(isum < 0, 320'(isum < 0 ? -isum : isum), 0);
        row_acc = fp_add(row_acc, fp_mul(scale, fsum));
        if (b.last) begin
            row_sums_due.push_back(is_nan(row_acc) ? F_QNAN : row_acc);
            row_acc = 32'h0;
        end
    endtask

    // ---------------- stimulus ----------------

    function automatic t_block rand_block(input logic last);
        t_block b;
        b.wlo = {$urandom, $urandom};
        b.whi = {$urandom, $urandom};
        for (int i = 0; i < 4; i++) b.acts[i] = {$urandom, $urandom};
        if ($urandom_range(9) == 0) begin
            b.wscale = 16'($urandom);
            b.ascale = $urandom;
        end else begin
            b.wscale = {1'($urandom), 5'($urandom_range(20, 8)), 10'($urandom)};
            b.ascale = {1'($urandom), 8'($urandom_range(132, 108)), 23'($urandom)};
        end
        b.last = last;
        return b;
    endfunction

    function automatic t_block fill_block(input logic [7:0] w, input logic [7:0] a,
                                          input logic [15:0] hs, input logic [31:0] as,
                                          input logic last);
        t_block b;
        b.wlo = {8{w}};
        b.whi = {8{w}};
        for (int i = 0; i < 4; i++) b.acts[i] = {8{a}};
        b.wscale = hs;
        b.ascale = as;
        b.last = last;
        return b;
    endfunction

    // call at a rising edge; returns at the edge where the word is taken
    task automatic send_block(input t_block b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.weight_bytes_low  <= b.wlo;
        in_ch.weight_bytes_high <= b.whi;
        in_ch.weight_scale      <= b.wscale;
        in_ch.acts_0            <= b.acts[0];
        in_ch.acts_1            <= b.acts[1];
        in_ch.acts_2            <= b.acts[2];
        in_ch.acts_3            <= b.acts[3];
        in_ch.act_scale         <= b.ascale;
        in_ch.last_block        <= b.last;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        accumulate_block(b);
    endtask

    task automatic wait_drained();
        while (row_sums_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_block b;
        send_block(fill_block(8'h00, 8'h00, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'hFF, 8'h7F, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'h00, 8'h80, 16'h3C00, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'hFF, 8'h80, 16'hBC00, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'h9A, 8'h05, 16'h0001, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'h9A, 8'hF3, 16'h83FF, 32'h4100_0000, 1'b1));
        send_block(fill_block(8'h9A, 8'h05, 16'h7C00, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'h9A, 8'h05, 16'hFE01, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'h9A, 8'h00, 16'h7C00, 32'h3F80_0000, 1'b1));
        send_block(fill_block(8'h9A, 8'h05, 16'h3C00, 32'h7F80_0000, 1'b0));
        send_block(fill_block(8'h9A, 8'h05, 16'h3C00, 32'hFF80_0000, 1'b1));
        send_block(fill_block(8'hFF, 8'h7F, 16'h7BFF, 32'h7F7F_FFFF, 1'b1));
        send_block(fill_block(8'h9A, 8'h05, 16'h3C00, 32'h0000_0001, 1'b1));
        send_block(fill_block(8'h9A, 8'h05, 16'h3C00, 32'h7FBF_FFFF, 1'b1));
        // cancel to exact zero
        b = rand_block(1'b0);
        send_block(b);
        b.ascale[31] = ~b.ascale[31];
        b.last = 1'b1;
        send_block(b);
        send_block(fill_block(8'h9A, 8'h05, 16'h8000, 32'h3F80_0000, 1'b1));
        for (int i = 0; i < 4; i++) send_block(rand_block(i == 3));
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 12; i++) send_block(rand_block(1'b1));
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 3; i++) send_block(rand_block(i == 2));
        in_ch.valid <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        send_block(rand_block(1'b1));
    endtask

    task automatic test_random(input int n_blocks);
        int sent;
        int row_len;
        sent = 0;
        while (sent < n_blocks) begin
            quiet = (sent < 80);
            row_len = $urandom_range(6, 1);
            for (int i = 0; i < row_len; i++) send_block(rand_block(i == row_len - 1));
            sent += row_len;
        end
        quiet = 1'b0;
    endtask

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen    <= hold_req;
            hold_cycles  <= HOLD_LONG - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(negedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (row_sums_due.size() == 0) begin
                $display("%0t: row sum with none due: expected none, actual %08h",
                         $time, out_ch.row_sum);
                errors++;
            end else begin
                want = row_sums_due.pop_front();
                if (out_ch.row_sum !== want) begin
                    $display("%0t: row_sum mismatch: expected %08h, actual %08h",
                             $time, want, out_ch.row_sum);
                    errors++;
                end
            end
        end
    end

    // count cycles in which no word moves on either side
    always @(negedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count > WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        in_ch.valid             = 1'b0;
        in_ch.weight_bytes_low  = '0;
        in_ch.weight_bytes_high = '0;
        in_ch.weight_scale      = '0;
        in_ch.acts_0            = '0;
        in_ch.acts_1            = '0;
        in_ch.acts_2            = '0;
        in_ch.acts_3            = '0;
        in_ch.act_scale         = '0;
        in_ch.last_block        = 1'b0;
        out_ch.ready            = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(400);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && row_sums_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/q4bd_pkg.sv
sv/q4bd_if.sv
sv/q4_block_dot_accumulator_unit.sv
sim/testbench.sv
